### src/bc_pkg.sv
// ----------------------------------------------------------------------------
// bc_pkg - binomial coefficient shared definitions
// Field widths, port widths and sizing constants for the iterative datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bc_pkg;

    // stream word layout
    localparam int IDX_W     = 7;                    // n_top / k_choose width
    localparam int S_TDATA_W = 16;                   // two indices, padded to bytes
    localparam int COEFF_W   = 29;
    localparam int M_TDATA_W = 32;                   // coeff, padded to bytes

    // largest n handled in the general case
    localparam int MAX_TOP   = 31;

    // datapath sizing (n <= 31 in the general case, so min(k, n-k) <= 15)
    localparam int TOP_W     = 5;                    // n in general case
    localparam int STEP_W    = 4;                    // step index j, divisor
    localparam int PROD_W    = COEFF_W + TOP_W;      // running value times (n-j+1)
    localparam int DIV_CNT_W = $clog2(PROD_W);

endpackage : bc_pkg

`default_nettype wire

### src/bc_div.sv
// ----------------------------------------------------------------------------
// bc_div - iterative restoring divider
// One quotient bit per cycle; a PROD_W-bit dividend by a STEP_W-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bc_pkg::PROD_W-1:0]     dividend,
    input  wire logic [bc_pkg::STEP_W-1:0]     divisor,
    output logic                               done,
    output logic [bc_pkg::PROD_W-1:0]          quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [bc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [bc_pkg::PROD_W-1:0]      quo_reg, quo_next;
    logic [bc_pkg::STEP_W-1:0]      rem_reg, rem_next;
    logic [bc_pkg::STEP_W-1:0]      dsr_reg, dsr_next;
    logic [bc_pkg::STEP_W:0]        rem_shift;
    logic [bc_pkg::STEP_W:0]        rem_sub;
    logic                           fits;

    // partial remainder stays below the divisor, so STEP_W+1 bits cover the shift
    assign rem_shift = {rem_reg, quo_reg[bc_pkg::PROD_W-1]};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bc_pkg::DIV_CNT_W'(bc_pkg::PROD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[bc_pkg::PROD_W-2:0], fits};
            rem_next = fits ? rem_sub[bc_pkg::STEP_W-1:0] : rem_shift[bc_pkg::STEP_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : bc_div

`default_nettype wire

### src/binomial_coefficient.sv
// ----------------------------------------------------------------------------
// binomial_coefficient - n choose k, multiplicative method
// Sequencer, one small multiplier and a shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one word carries a signed pair (n, k). s_tready is high
//   only while the sequencer is idle, so one word is in work at a time.
//   Master stream m_*: one word per input word, coeff in m_tdata, the
//   overflow flag in m_tuser.
// Special cases (k zero or k equal to n, out-of-domain pairs, n above
// MAX_TOP) are settled in the accept cycle; the result then passes through
// ST_DONE into the output register, which raises m_tvalid. General case:
// for j = 1 .. min(k, n-k) the running value is multiplied by (n-j+1) in
// ST_MUL, then divided exactly by j in the shared restoring divider, one
// quotient bit per cycle. s_tready returns in the same cycle as the result
// moves into the output register.
// Stall: a result waits in the output register while m_tready is low; a
// finished result behind it waits in the sequencer, which then holds off s_*.
// Reset (rst_n low, asynchronous) empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient
#(
    parameter int MAX_TOP = bc_pkg::MAX_TOP                 // 2 .. 31
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bc_pkg::S_TDATA_W-1:0]     s_tdata,   // [6:0] n_top, [13:7] k_choose
    // master stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bc_pkg::M_TDATA_W-1:0]          m_tdata,   // [28:0] coeff
    output logic                                  m_tuser    // [0] overflow
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam logic [bc_pkg::STEP_W-1:0] STEP_ONE = bc_pkg::STEP_W'(1);

    state_t                         state_reg, state_next;
    logic [bc_pkg::COEFF_W-1:0]     acc_reg, acc_next;      // running value C(n, j)
    logic                           ovf_reg, ovf_next;
    logic [bc_pkg::TOP_W-1:0]       top_reg, top_next;      // n
    logic [bc_pkg::STEP_W-1:0]      j_reg, j_next;          // current step
    logic [bc_pkg::STEP_W-1:0]      m_reg, m_next;          // last step
    logic                           out_valid_reg, out_valid_next;
    logic [bc_pkg::COEFF_W-1:0]     out_coeff_reg, out_coeff_next;
    logic                           out_ovf_reg, out_ovf_next;

    // input word decode
    logic signed [bc_pkg::IDX_W-1:0] n_in;
    logic signed [bc_pkg::IDX_W-1:0] k_in;
    logic [bc_pkg::TOP_W-1:0]        n_lo;
    logic [bc_pkg::TOP_W-1:0]        k_lo;
    logic [bc_pkg::TOP_W-1:0]        nk_lo;
    logic                            accept;

    // multiply / divide datapath
    logic [bc_pkg::TOP_W-1:0]        factor;
    logic [bc_pkg::PROD_W-1:0]       product;
    logic                            div_start;
    logic                            div_done;
    logic [bc_pkg::PROD_W-1:0]       div_quo;

    assign n_in   = $signed(s_tdata[bc_pkg::IDX_W-1:0]);
    assign k_in   = $signed(s_tdata[2*bc_pkg::IDX_W-1:bc_pkg::IDX_W]);
    assign n_lo   = n_in[bc_pkg::TOP_W-1:0];
    assign k_lo   = k_in[bc_pkg::TOP_W-1:0];
    assign nk_lo  = n_lo - k_lo;
    assign accept = s_tvalid && s_tready;

    // n - j + 1 stays in 1 .. 31
    assign factor    = top_reg - bc_pkg::TOP_W'(j_reg) + 1'b1;
    assign product   = bc_pkg::PROD_W'(acc_reg) * bc_pkg::PROD_W'(factor);
    assign div_start = (state_reg == ST_MUL);

    bc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (j_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        top_next       = top_reg;
        j_next         = j_reg;
        m_next         = m_reg;
        out_valid_next = out_valid_reg;
        out_coeff_next = out_coeff_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ovf_next   = 1'b0;
                    top_next   = n_lo;
                    j_next     = STEP_ONE;
                    acc_next   = bc_pkg::COEFF_W'(1);
                    // min(k, n-k), valid in the general case only
                    m_next     = (k_lo < nk_lo) ? k_lo[bc_pkg::STEP_W-1:0]
                                                : nk_lo[bc_pkg::STEP_W-1:0];
                    state_next = ST_DONE;
                    priority if (k_in == '0 || n_in == k_in)
                    begin
                        acc_next = bc_pkg::COEFF_W'(1);
                    end
                    else if (n_in < 0 || k_in < 0 || k_in > n_in)
                    begin
                        acc_next = '0;
                    end
                    else if (n_in > $signed(bc_pkg::IDX_W'(MAX_TOP)))
                    begin
                        acc_next = '0;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                // product is captured by the divider this cycle
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    acc_next = div_quo[bc_pkg::COEFF_W-1:0];
                    if (j_reg == m_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_coeff_next = acc_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        ovf_reg       <= ovf_next;
        top_reg       <= top_next;
        j_reg         <= j_next;
        m_reg         <= m_next;
        out_coeff_reg <= out_coeff_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bc_pkg::M_TDATA_W'(out_coeff_reg);
    assign m_tuser  = out_ovf_reg;

endmodule : binomial_coefficient

`default_nettype wire

### src/bc_checker.sv
// ----------------------------------------------------------------------------
// bc_checker - port-level checks for binomial_coefficient
// Watches the two stream groups; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_checker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [bc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                             m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new word taken while busy");

    // overflow saturates the coefficient to zero
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("overflow with non-zero coefficient");

    // pad bits above coeff stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[bc_pkg::M_TDATA_W-1:bc_pkg::COEFF_W] == '0)
        else $error("pad bits set in result word");

endmodule : bc_checker

bind binomial_coefficient bc_checker u_bc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for binomial_coefficient
// Drives (n, k) pairs on the slave stream and predicts n choose k plus the
// overflow flag for each accepted word. Results on the master stream are
// compared in order. A short directed set comes first, then about 1150 random
// pairs, mostly from the general case. Both sides idle at random, and the
// receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [bc_pkg::IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [bc_pkg::COEFF_W-1:0] coeff;
        logic                       overflow;
    } coeff_word_t;

    // ------------------------------------------------------------------------
    // Expected-result store with its own n-choose-k predictor
    // ------------------------------------------------------------------------
    class coeff_scoreboard;
        coeff_word_t expected_q[$];
        int unsigned n_fail;

        // n choose k, multiplicative form; the step after j holds C(n, j)
        function coeff_word_t choose(idx_t n, idx_t k);
            coeff_word_t     w;
            int              nn;
            int              kk;
            int              m;
            int              j;
            longint unsigned acc;
            nn = n;
            kk = k;
            w.coeff    = '0;
            w.overflow = 1'b0;
            if (kk == 0 || nn == kk)
                w.coeff = 1;                    // checked first, so negatives too
            else if (nn < 0 || kk < 0 || kk > nn)
                w.coeff = '0;                   // outside the domain
            else if (nn > bc_pkg::MAX_TOP)
                w.overflow = 1'b1;              // saturates to zero
            else
            begin
                m   = (kk < nn - kk) ? kk : nn - kk;
                acc = 1;
                for (j = 1; j <= m; j++)
                begin
                    acc = acc * longint'(nn - j + 1);
                    acc = acc / longint'(j);
                end
                w.coeff = acc[bc_pkg::COEFF_W-1:0];
            end
            return w;
        endfunction

        function void note_pair(idx_t n, idx_t k);
            expected_q.push_back(choose(n, k));
        endfunction

        task report(string msg);
            n_fail++;
            if (n_fail <= 40)
                $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task check_word(logic [bc_pkg::COEFF_W-1:0] coeff, logic overflow);
            coeff_word_t exp_w;
            if (expected_q.size() == 0)
                report($sformatf("result word with nothing pending (coeff %0d)", coeff));
            else
            begin
                exp_w = expected_q.pop_front();
                if (coeff !== exp_w.coeff)
                    report($sformatf("coeff %0d, expected %0d", coeff, exp_w.coeff));
                if (overflow !== exp_w.overflow)
                    report($sformatf("overflow %b, expected %b", overflow, exp_w.overflow));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and stream signals
    // ------------------------------------------------------------------------
    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bc_pkg::S_TDATA_W-1:0] s_tdata;      // [6:0] n_top, [13:7] k_choose
    logic                         m_tvalid;
    logic                         m_tready;
    logic [bc_pkg::M_TDATA_W-1:0] m_tdata;      // [28:0] coeff
    logic                         m_tuser;      // [0] overflow

    binomial_coefficient dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    coeff_scoreboard sb = new;

    // quiet phases: one side stops idling for a stretch of words
    bit quiet_tx;
    bit quiet_rx;

    // 125 MHz
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Both handshakes are sampled at the edge, before any NBA update lands,
    // so the monitor sees exactly what the DUT saw.
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_pair(idx_t'(s_tdata[bc_pkg::IDX_W-1:0]),
                         idx_t'(s_tdata[2*bc_pkg::IDX_W-1:bc_pkg::IDX_W]));
        if (m_tvalid && m_tready)
            sb.check_word(m_tdata[bc_pkg::COEFF_W-1:0], m_tuser);
    end

    // ------------------------------------------------------------------------
    // Sender: one word per call, optional gap first. Valid is only dropped
    // when a gap is drawn, so back-to-back words keep it high.
    // ------------------------------------------------------------------------
    task automatic send_pair(idx_t n, idx_t k);
        int unsigned gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bc_pkg::S_TDATA_W - 2*bc_pkg::IDX_W){1'b0}}, k, n};
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random hold-off per word, quiet stretches, and one long
    // stall after 150 words so the output register and the sequencer both
    // fill and s_tready drops while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            quiet_rx = ((taken / 100) % 3 == 1);
            if (taken == 150)
                hold = 3000;
            else
                hold = quiet_rx ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    // directed pairs: both extremes, equal negatives, each out-of-domain
    // kind, overflow just past MAX_TOP and at the top, and the largest result
    int dir_n[] = '{0, -64, 63, 63, -64, -5, -1, -64,   5,  20, 5, -64,  63,
                    32, 63, 63, 31, 31, 31, 31, 30, 2, 7, 31, 1};
    int dir_k[] = '{0, -64, 63,  0,   0, -5,  3,   5,  -1, -64, 6,  63, -64,
                    5,   1, 62,  1, 30, 15, 16, 15, 1, 3, -1, 0};

    initial
    begin : stimulus
        int nn;
        int kk;
        int sel;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_n[i])
            send_pair(idx_t'(dir_n[i]), idx_t'(dir_k[i]));

        for (int i = 0; i < 1150; i++)
        begin
            quiet_tx = ((i / 90) % 4 == 2);
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                // general case, real multiply/divide work
                nn = $urandom_range(2, bc_pkg::MAX_TOP);
                kk = $urandom_range(1, nn - 1);
            end
            else if (sel < 63)
            begin
                // n above MAX_TOP with a general-case k
                nn = $urandom_range(bc_pkg::MAX_TOP + 1, 63);
                kk = $urandom_range(1, nn - 1);
            end
            else if (sel < 73)
            begin
                // k zero or k equal to n, any sign
                nn = int'($urandom_range(0, 127)) - 64;
                kk = ($urandom_range(0, 1) != 0) ? 0 : nn;
            end
            else if (sel < 85)
            begin
                // out of domain: negative n, negative k or k above n
                case ($urandom_range(0, 2))
                    0:
                    begin
                        nn = int'($urandom_range(0, 63)) - 64;
                        kk = $urandom_range(0, 127);
                    end
                    1:
                    begin
                        nn = $urandom_range(0, 127);
                        kk = int'($urandom_range(0, 63)) - 64;
                    end
                    default:
                    begin
                        nn = int'($urandom_range(0, 126)) - 64;
                        kk = $urandom_range(nn + 65, 127) - 64;
                    end
                endcase
            end
            else
            begin
                // raw bit patterns
                nn = $urandom_range(0, 127);
                kk = $urandom_range(0, 127);
            end
            send_pair(idx_t'(nn), idx_t'(kk));
        end
        s_tvalid <= 1'b0;

        // drain, then give any stray word time to show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // timeout set well above the worst-case run time
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/bc_pkg.sv
src/bc_div.sv
src/binomial_coefficient.sv
src/bc_checker.sv
tb/tb.sv
